@@ rtl/tdbs_pkg.sv @@
// Package with shared widths, codes and constants of the tape DMA block sequencer.
`timescale 1ns / 1ps

package tdbs_pkg;

    localparam int ADDR_W   = 24;
    localparam int COUNT_W  = 17;
    localparam int STATUS_W = 8;
    localparam int CHAN_W   = 2;

    localparam int BLOCK_BYTES_DEFAULT = 512;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register index of the single configuration register.
    localparam logic [APB_ADDR_W-3:0] REG_DMA_CHANNEL = '0;

    // Controller status bits, both active low.
    localparam int ST_READY_BIT = 0;
    localparam int ST_EXCEP_BIT = 1;

    localparam logic [STATUS_W-1:0] MODE_READ  = 8'h44;
    localparam logic [STATUS_W-1:0] MODE_WRITE = 8'h48;

    localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd1;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_EVENT = 1'b1
    } op_t;

    typedef enum logic [M_TUSER_W-1:0] {
        ACT_NONE          = 3'd0,
        ACT_PROGRAM       = 3'd1,
        ACT_DONE_NORMAL   = 3'd2,
        ACT_DONE_EXCEPT   = 3'd3,
        ACT_REFUSE_EXCEPT = 3'd4,
        ACT_REFUSE_NRDY   = 3'd5
    } action_t;

    // A channel value of zero acts as channel one.
    function automatic logic [CHAN_W-1:0] eff_channel(input logic [CHAN_W-1:0] ch);
        return (ch == '0) ? CHAN_RESET : ch;
    endfunction

endpackage

@@ rtl/tape_dma_block_sequencer.sv @@
// Top level of the tape DMA block sequencer: input beat register, update logic, result register.
`timescale 1ns / 1ps

// The sequencer walks a tape transfer through DMA blocks of BLOCK_BYTES bytes. Each input
// beat is either a start (tuser low) or an interrupt event (tuser high), and every input
// beat yields exactly one result beat whose tuser carries the action code: program a block,
// finish normally, finish on a controller exception, refuse a start, or do nothing. An
// input beat is registered, then processed against the transfer state while the result
// is loaded into the output register, so a beat can enter every cycle while the sink
// does not stall. The only backpressure path is the output register: when it is full
// and the sink stalls, a full input register holds and s_axis_tready drops. The DMA
// channel register sits at byte address 0 of the APB port and should only be changed
// while no beat is in flight.
module tape_dma_block_sequencer
    #(
    parameter int BLOCK_BYTES = tdbs_pkg::BLOCK_BYTES_DEFAULT
    )
    (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tdbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tdbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // start_address[23:0], byte_count[40:24], write_tape[41], controller_status[49:42],
    // dma_status[57:50], zero fill[63:58]
    input  logic [tdbs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic                            s_axis_tuser,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // dma_address[23:0], dma_mode[31:24], bytes_done[48:32], transfer_complete[49],
    // exception_seen[50], zero fill[55:51]
    output logic [tdbs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // action[2:0]
    output logic [tdbs_pkg::M_TUSER_W-1:0]  m_axis_tuser
    );

    import tdbs_pkg::*;

    localparam logic [COUNT_W:0] BLOCK_INC   = (COUNT_W+1)'(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] BLOCK_STEP = ADDR_W'(BLOCK_BYTES);

    // Configuration register
    logic [CHAN_W-1:0] dma_channel_reg;
    logic              cfg_write;

    // Input beat register
    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [ADDR_W-1:0]    in_addr_reg;
    logic [COUNT_W-1:0]   in_count_reg;
    logic                 in_write_reg;
    logic [STATUS_W-1:0]  in_cstat_reg;
    logic [STATUS_W-1:0]  in_dstat_reg;

    // Transfer state
    logic [ADDR_W-1:0]  block_address_reg, block_address_next;
    logic [COUNT_W-1:0] total_bytes_reg, total_bytes_next;
    logic [COUNT_W-1:0] done_bytes_reg, done_bytes_next;
    logic               active_reg, active_next;
    logic               write_dir_reg, write_dir_next;
    logic               complete_reg, complete_next;
    logic               exception_reg, exception_next;

    // Result register
    logic               out_valid_reg;
    action_t            out_action_reg, action_next;
    logic [ADDR_W-1:0]  out_addr_reg, addr_next;
    logic [STATUS_W-1:0] out_mode_reg, mode_next;
    logic [COUNT_W-1:0] out_done_reg;
    logic               out_complete_reg;
    logic               out_exception_reg;

    logic               out_free;
    logic               process;
    logic [CHAN_W-1:0]  chan;
    logic               tc_hit;
    logic [COUNT_W:0]   next_count;

    // ------------------------------------------------------------------
    // APB register: writes land on the access cycle; reads are combinational.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1:2] == REG_DMA_CHANNEL);

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_DMA_CHANNEL)
        begin
            prdata = {{(APB_DATA_W-CHAN_W){1'b0}}, dma_channel_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dma_channel_reg <= CHAN_RESET;
        end
        else if (cfg_write)
        begin
            dma_channel_reg <= pwdata[CHAN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake: a beat in the input register is processed when the output
    // register is empty or being drained this cycle.
    // ------------------------------------------------------------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg    <= s_axis_tuser;
            in_addr_reg  <= s_axis_tdata[23:0];
            in_count_reg <= s_axis_tdata[40:24];
            in_write_reg <= s_axis_tdata[41];
            in_cstat_reg <= s_axis_tdata[49:42];
            in_dstat_reg <= s_axis_tdata[57:50];
        end
    end

    // ------------------------------------------------------------------
    // Update logic for one beat.
    // ------------------------------------------------------------------
    assign chan       = eff_channel(dma_channel_reg);
    assign tc_hit     = in_dstat_reg[{1'b0, chan}];
    assign next_count = {1'b0, done_bytes_reg} + BLOCK_INC;

    always_comb
    begin
        block_address_next = block_address_reg;
        total_bytes_next   = total_bytes_reg;
        done_bytes_next    = done_bytes_reg;
        active_next        = active_reg;
        write_dir_next     = write_dir_reg;
        complete_next      = complete_reg;
        exception_next     = exception_reg;
        action_next        = ACT_NONE;
        addr_next          = '0;
        mode_next          = '0;

        if (in_op_reg == OP_START)
        begin
            // A start always reloads the transfer, even when it is refused.
            block_address_next = in_addr_reg;
            total_bytes_next   = in_count_reg;
            write_dir_next     = in_write_reg;
            done_bytes_next    = '0;
            complete_next      = 1'b0;
            exception_next     = 1'b0;
            if (!in_cstat_reg[ST_EXCEP_BIT])
            begin
                active_next = 1'b0;
                action_next = ACT_REFUSE_EXCEPT;
            end
            else if (in_cstat_reg[ST_READY_BIT])
            begin
                active_next = 1'b0;
                action_next = ACT_REFUSE_NRDY;
            end
            else
            begin
                active_next = 1'b1;
                action_next = ACT_PROGRAM;
                addr_next   = in_addr_reg;
                mode_next   = (in_write_reg ? MODE_WRITE : MODE_READ)
                              + {{(STATUS_W-CHAN_W){1'b0}}, chan};
            end
        end
        else if (active_reg)
        begin
            if (!in_cstat_reg[ST_EXCEP_BIT])
            begin
                // The exception ends the transfer; the count is not advanced.
                if (next_count >= {1'b0, total_bytes_reg})
                begin
                    complete_next = 1'b1;
                end
                exception_next = 1'b1;
                active_next    = 1'b0;
                action_next    = ACT_DONE_EXCEPT;
            end
            else if (!in_cstat_reg[ST_READY_BIT] && tc_hit)
            begin
                exception_next  = 1'b0;
                done_bytes_next = next_count[COUNT_W] ? COUNT_MAX : next_count[COUNT_W-1:0];
                if (next_count >= {1'b0, total_bytes_reg})
                begin
                    complete_next = 1'b1;
                    active_next   = 1'b0;
                    action_next   = ACT_DONE_NORMAL;
                end
                else
                begin
                    block_address_next = block_address_reg + BLOCK_STEP;
                    action_next        = ACT_PROGRAM;
                    addr_next          = block_address_reg + BLOCK_STEP;
                    mode_next          = (write_dir_reg ? MODE_WRITE : MODE_READ)
                                         + {{(STATUS_W-CHAN_W){1'b0}}, chan};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_address_reg <= '0;
            total_bytes_reg   <= '0;
            done_bytes_reg    <= '0;
            active_reg        <= 1'b0;
            write_dir_reg     <= 1'b0;
            complete_reg      <= 1'b0;
            exception_reg     <= 1'b0;
        end
        else if (process)
        begin
            block_address_reg <= block_address_next;
            total_bytes_reg   <= total_bytes_next;
            done_bytes_reg    <= done_bytes_next;
            active_reg        <= active_next;
            write_dir_reg     <= write_dir_next;
            complete_reg      <= complete_next;
            exception_reg     <= exception_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_action_reg    <= action_next;
            out_addr_reg      <= addr_next;
            out_mode_reg      <= mode_next;
            out_done_reg      <= done_bytes_next;
            out_complete_reg  <= complete_next;
            out_exception_reg <= exception_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tdata  = {5'b0, out_exception_reg, out_complete_reg, out_done_reg,
                            out_mode_reg, out_addr_reg};

endmodule
